### rtl/rrcb_pkg.sv
package rrcb_pkg;

  localparam int MAX_DIM_DEF   = 2048;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_WIDTH    = 3'd0,
    REG_RECT_HEIGHT   = 3'd1,
    REG_RADIUS_TL     = 3'd2,
    REG_RADIUS_TR     = 3'd3,
    REG_RADIUS_BL     = 3'd4,
    REG_RADIUS_BR     = 3'd5,
    REG_FILL_COLOR    = 3'd6
  } cfg_reg_t;

  localparam logic [11:0] RESET_DIM = 12'd64;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [7:0]  dst_red;
    logic [7:0]  dst_green;
    logic [7:0]  dst_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       covered;
    logic [8:0] coverage;
  } result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

### rtl/rrcb_stream_if.sv
interface rrcb_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/rounded_rect_coverage_blend_core.sv
// Antialiased rounded-rectangle fill, one pixel per transaction.
// pixel  : sink channel, valid/ready, carries pixel_x, pixel_y and the opaque
//          destination color.
// result : source channel, valid/ready, carries the blended color, covered
//          and coverage (1/256 units).
// cfg_*  : write port for size, the four corner radii and fill_color; write
//          only while no transaction is in flight.
// Throughput: one pixel per clock. All stages advance together whenever the
// output register is empty or being taken.
// Stages in order: offsets, squared distance, RW square-root cells (one per root
// bit), then the blend unit's registers.
// Reset: clears all valid flags and loads 64x64, zero radii, zero fill color.
// When result is stalled with a full output register, pixel.ready drops and
// the whole pipeline holds.
module rounded_rect_coverage_blend_core #(
  parameter int MAX_DIM   = rrcb_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = rrcb_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rrcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrcb_pkg::CFG_W-1:0]      cfg_data,
  rrcb_stream_if.sink                     pixel,
  rrcb_stream_if.source                   result
);

  localparam int DIM_CAP = (MAX_DIM < 4095) ? MAX_DIM : 4095;
  localparam int DIM_W   = $clog2(DIM_CAP + 1);
  localparam int GW      = ((DIM_W + 2 > 13) ? DIM_W + 2 : 13) + 1;
  localparam int MW      = GW - 1;
  localparam int SQW     = 2 * MW + 1;
  localparam int VW      = SQW + 2 * FRAC_BITS - 2;
  localparam int RW      = (VW + 1) / 2;
  localparam int CW      = VW + 1;
  localparam int R2W     = DIM_W;
  localparam int SBW     = 1 + R2W + 24;

  // configuration
  logic [11:0] rect_width, rect_height;
  logic [10:0] radius_tl, radius_tr, radius_bl, radius_br;
  logic [31:0] fill_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_width  <= rrcb_pkg::RESET_DIM;
      rect_height <= rrcb_pkg::RESET_DIM;
      radius_tl   <= '0;
      radius_tr   <= '0;
      radius_bl   <= '0;
      radius_br   <= '0;
      fill_color  <= '0;
    end else if (cfg_we) begin
      unique case (rrcb_pkg::cfg_reg_t'(cfg_index))
        rrcb_pkg::REG_RECT_WIDTH:  rect_width  <= cfg_data[11:0];
        rrcb_pkg::REG_RECT_HEIGHT: rect_height <= cfg_data[11:0];
        rrcb_pkg::REG_RADIUS_TL:   radius_tl   <= cfg_data[10:0];
        rrcb_pkg::REG_RADIUS_TR:   radius_tr   <= cfg_data[10:0];
        rrcb_pkg::REG_RADIUS_BL:   radius_bl   <= cfg_data[10:0];
        rrcb_pkg::REG_RADIUS_BR:   radius_br   <= cfg_data[10:0];
        rrcb_pkg::REG_FILL_COLOR:  fill_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en          = !result.valid || result.ready;
  assign pixel.ready = en;

  // geometry, all in half-pixel units
  logic [DIM_W-1:0]      w_sat, h_sat, lim;
  logic signed [GW-1:0]  lim_s, x2, y2, w2, h2, tl, tr, bl, br;
  logic signed [GW-1:0]  off_x, off_y, r_sel;
  logic                  any_r, hit;
  logic [MW-1:0]         mag_x, mag_y;

  function automatic logic signed [GW-1:0] clamp2(input logic [10:0] r,
                                                  input logic signed [GW-1:0] l);
    logic signed [GW-1:0] r2;
    r2 = $signed(GW'({r, 1'b0}));
    return (r2 > l) ? l : r2;
  endfunction

  assign w_sat = (32'(rect_width) > 32'(DIM_CAP)) ? DIM_W'(DIM_CAP) : DIM_W'(rect_width);
  assign h_sat = (32'(rect_height) > 32'(DIM_CAP)) ? DIM_W'(DIM_CAP) : DIM_W'(rect_height);
  assign lim   = (w_sat < h_sat) ? w_sat : h_sat;
  assign lim_s = $signed(GW'(lim));
  assign x2    = $signed(GW'({pixel.payload.pixel_x, 1'b0}));
  assign y2    = $signed(GW'({pixel.payload.pixel_y, 1'b0}));
  assign w2    = $signed(GW'({w_sat, 1'b0}));
  assign h2    = $signed(GW'({h_sat, 1'b0}));
  assign tl    = clamp2(radius_tl, lim_s);
  assign tr    = clamp2(radius_tr, lim_s);
  assign bl    = clamp2(radius_bl, lim_s);
  assign br    = clamp2(radius_br, lim_s);
  assign any_r = |{radius_tl, radius_tr, radius_bl, radius_br};

  localparam logic signed [GW-1:0] ONE_PX = GW'(2);

  always_comb begin
    hit   = 1'b0;
    off_x = '0;
    off_y = '0;
    r_sel = '0;
    if (any_r) begin
      if (x2 < tl && y2 < tl) begin
        hit = 1'b1; r_sel = tl;
        off_x = tl - x2 - ONE_PX; off_y = tl - y2 - ONE_PX;
      end else if (x2 >= w2 - tr && y2 < tr) begin
        hit = 1'b1; r_sel = tr;
        off_x = x2 - (w2 - tr); off_y = tr - y2 - ONE_PX;
      end else if (x2 < bl && y2 >= h2 - bl) begin
        hit = 1'b1; r_sel = bl;
        off_x = bl - x2 - ONE_PX; off_y = y2 - (h2 - bl);
      end else if (x2 >= w2 - br && y2 >= h2 - br) begin
        hit = 1'b1; r_sel = br;
        off_x = x2 - (w2 - br); off_y = y2 - (h2 - br);
      end
    end
  end

  assign mag_x = MW'((off_x < 0) ? -off_x : off_x);
  assign mag_y = MW'((off_y < 0) ? -off_y : off_y);

  // stage 0: offsets
  logic           s0_valid, s0_hit;
  logic [R2W-1:0] s0_r2;
  logic [MW-1:0]  s0_mx, s0_my;
  rrcb_pkg::rgb_t s0_dst;
  // stage 1: squared distance
  logic           s1_valid, s1_hit;
  logic [R2W-1:0] s1_r2;
  logic [SQW-1:0] s1_sq;
  rrcb_pkg::rgb_t s1_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= pixel.valid;
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_hit       <= hit;
      s0_r2        <= R2W'(r_sel);
      s0_mx        <= mag_x;
      s0_my        <= mag_y;
      s0_dst.red   <= pixel.payload.dst_red;
      s0_dst.green <= pixel.payload.dst_green;
      s0_dst.blue  <= pixel.payload.dst_blue;

      s1_hit <= s0_hit;
      s1_r2  <= s0_r2;
      s1_dst <= s0_dst;
      s1_sq  <= SQW'(s0_mx * s0_mx) + SQW'(s0_my * s0_my);
    end
  end

  // square-root cell row, most significant root bit first
  logic           c_valid [RW+1];
  logic [CW-1:0]  c_rem   [RW+1];
  logic [CW-1:0]  c_root  [RW+1];
  logic [SBW-1:0] c_side  [RW+1];

  assign c_valid[0] = s1_valid;
  assign c_rem[0]   = CW'(s1_sq) << (2 * FRAC_BITS - 2);
  assign c_root[0]  = '0;
  assign c_side[0]  = {s1_hit, s1_r2, s1_dst};

  for (genvar k = 0; k < RW; k++) begin : g_cell
    rrcb_sqrt_cell #(.W(CW), .BIT_POS(RW - 1 - k), .SBW(SBW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (c_valid[k]),
      .in_rem    (c_rem[k]),
      .in_root   (c_root[k]),
      .in_side   (c_side[k]),
      .out_valid (c_valid[k+1]),
      .out_rem   (c_rem[k+1]),
      .out_root  (c_root[k+1]),
      .out_side  (c_side[k+1])
    );
  end

  logic           t_hit;
  logic [R2W-1:0] t_r2;
  rrcb_pkg::rgb_t t_dst;
  assign {t_hit, t_r2, t_dst} = c_side[RW];

  rrcb_blend #(.FRAC_BITS(FRAC_BITS), .RW(RW), .R2W(R2W)) u_blend (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (c_valid[RW]),
    .in_hit     (t_hit),
    .in_r2      (t_r2),
    .in_dist    (c_root[RW][RW-1:0]),
    .in_dst     (t_dst),
    .fill_color (fill_color),
    .out_valid  (result.valid),
    .out_item   (result.payload)
  );

  a_cov_flag: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.payload.covered == (result.payload.coverage != 9'd0)))
    else $error("covered flag disagrees with coverage");

  a_cov_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.payload.coverage <= 9'd256))
    else $error("coverage above full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(s0_valid) && $stable(c_valid[RW])))
    else $error("pipeline moved while stalled");

endmodule

### rtl/rrcb_sqrt_cell.sv
module rrcb_sqrt_cell #(
  parameter int W       = 44,
  parameter int BIT_POS = 0,
  parameter int SBW     = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [W-1:0]   in_rem,
  input  logic [W-1:0]   in_root,
  input  logic [SBW-1:0] in_side,
  output logic           out_valid,
  output logic [W-1:0]   out_rem,
  output logic [W-1:0]   out_root,
  output logic [SBW-1:0] out_side
);

  localparam logic [W-1:0] BIT = W'(1) << (2 * BIT_POS);

  logic [W-1:0] trial;
  logic         take;

  assign trial = in_root + BIT;
  assign take  = in_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? in_rem - trial : in_rem;
      out_root <= take ? (in_root >> 1) + BIT : in_root >> 1;
      out_side <= in_side;
    end
  end

endmodule

### rtl/rrcb_blend.sv
module rrcb_blend #(
  parameter int FRAC_BITS = rrcb_pkg::FRAC_BITS_DEF,
  parameter int RW        = 22,
  parameter int R2W       = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic              in_hit,
  input  logic [R2W-1:0]    in_r2,
  input  logic [RW-1:0]     in_dist,
  input  rrcb_pkg::rgb_t    in_dst,
  input  logic [31:0]       fill_color,
  output logic              out_valid,
  output rrcb_pkg::result_t out_item
);

  localparam int CMPW = ((RW > R2W + FRAC_BITS) ? RW : R2W + FRAC_BITS) + 1;
  localparam int COVW = FRAC_BITS + 9;
  localparam int SH_L = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  localparam int SH_R = (FRAC_BITS < 8) ? 0 : FRAC_BITS - 8;
  localparam logic [FRAC_BITS:0] COV_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [15:0] FULL_ALPHA = 16'd65280;

  function automatic logic [7:0] div_full_alpha(input logic [23:0] num);
    logic [15:0] n;
    logic [24:0] p;
    logic [7:0]  q0;
    logic [16:0] rem;
    n   = num[23:8];
    p   = {1'b0, n, 8'b0} + 25'(n);
    q0  = 8'(p >> 16);
    rem = 17'(n) - ({1'b0, q0, 8'b0} - 17'(q0));
    return (rem >= 17'd255) ? q0 + 8'd1 : q0;
  endfunction

  logic signed [CMPW-1:0] rf, rm1, dist_s, diff;
  logic [FRAC_BITS:0]     cov_f;
  logic [COVW-1:0]        cov_wide;
  logic [8:0]             cov256;

  assign rf       = $signed(CMPW'(in_r2) << (FRAC_BITS - 1));
  assign rm1      = rf - $signed(CMPW'(1) << FRAC_BITS);
  assign dist_s   = $signed(CMPW'(in_dist));
  assign diff     = rf - dist_s;

  always_comb begin
    if (!in_hit) begin
      cov_f = COV_ONE;
    end else if (dist_s > rf) begin
      cov_f = '0;
    end else if (dist_s <= rm1) begin
      cov_f = COV_ONE;
    end else begin
      cov_f = (FRAC_BITS + 1)'(diff);
    end
  end

  assign cov_wide = COVW'(cov_f) << SH_L;
  assign cov256   = 9'(cov_wide >> SH_R);

  // coverage stage
  logic           c_valid;
  logic [8:0]     c_cov;
  rrcb_pkg::rgb_t c_dst;
  // alpha stage
  logic           m_valid;
  logic [8:0]     m_cov;
  logic [15:0]    m_a;
  rrcb_pkg::rgb_t m_dst;
  // numerator stage
  logic           n_valid;
  logic [8:0]     n_cov;
  logic [23:0]    n_num [3];
  rrcb_pkg::rgb_t n_dst;

  logic [7:0]  fc [3];
  logic [7:0]  dc [3];
  logic [15:0] ia;

  assign fc[0] = fill_color[23:16];
  assign fc[1] = fill_color[15:8];
  assign fc[2] = fill_color[7:0];
  assign dc[0] = m_dst.red;
  assign dc[1] = m_dst.green;
  assign dc[2] = m_dst.blue;
  assign ia    = FULL_ALPHA - m_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      m_valid   <= 1'b0;
      n_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      c_valid   <= in_valid;
      m_valid   <= c_valid;
      n_valid   <= m_valid;
      out_valid <= n_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_cov <= cov256;
      c_dst <= in_dst;

      m_cov <= c_cov;
      m_dst <= c_dst;
      m_a   <= 16'({9'b0, fill_color[31:24]} * {8'b0, c_cov});

      n_cov <= m_cov;
      n_dst <= m_dst;
      for (int i = 0; i < 3; i++) begin
        n_num[i] <= 24'({16'b0, fc[i]} * {8'b0, m_a}) + 24'({16'b0, dc[i]} * {8'b0, ia});
      end

      if (n_cov != 9'd0) begin
        out_item.out_red   <= div_full_alpha(n_num[0]);
        out_item.out_green <= div_full_alpha(n_num[1]);
        out_item.out_blue  <= div_full_alpha(n_num[2]);
        out_item.covered   <= 1'b1;
        out_item.coverage  <= n_cov;
      end else begin
        out_item.out_red   <= n_dst.red;
        out_item.out_green <= n_dst.green;
        out_item.out_blue  <= n_dst.blue;
        out_item.covered   <= 1'b0;
        out_item.coverage  <= 9'd0;
      end
    end
  end

endmodule

### dv/rrcb_tb_if.sv
interface rrcb_cfg_if ();
  logic                           we;
  logic [rrcb_pkg::CFG_IDX_W-1:0] index;
  logic [rrcb_pkg::CFG_W-1:0]     data;
endinterface

### dv/rrcb_checker.sv
module rrcb_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rrcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrcb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           pix_valid,
  input  logic                           pix_ready,
  input  rrcb_pkg::pixel_t               pix,
  input  logic                           res_valid,
  input  logic                           res_ready,
  input  rrcb_pkg::result_t              res,
  output int                             errors,
  output int                             pending,
  output int                             covered_cnt,
  output int                             partial_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [11:0]       width_q, height_q;
  logic [10:0]       rad_q [4];
  logic [31:0]       fill_q;
  rrcb_pkg::result_t expected_px [$];

  function automatic longint unsigned root_trunc(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint corner_coverage(longint r2, longint dx, longint dy);
    longint unsigned sq;
    longint d, rf, rm1;
    sq = longint'(dx * dx) + longint'(dy * dy);
    d = longint'(root_trunc(sq << 14));
    rf = r2 * 128;
    rm1 = (r2 - 2) * 128;
    if (d > rf) return 0;
    if (d <= rm1) return 256;
    return rf - d;
  endfunction

  function automatic rrcb_pkg::result_t blend_pixel(rrcb_pkg::pixel_t p);
    rrcb_pkg::result_t o;
    longint x2, y2, w, h, w2, h2, lim, cov;
    longint c [4];
    longint unsigned a, ia;
    x2 = 2 * longint'(p.pixel_x);
    y2 = 2 * longint'(p.pixel_y);
    w = width_q > 2048 ? 2048 : width_q;
    h = height_q > 2048 ? 2048 : height_q;
    w2 = 2 * w;
    h2 = 2 * h;
    lim = w < h ? w : h;
    cov = 256;
    if ((rad_q[0] | rad_q[1] | rad_q[2] | rad_q[3]) != 0) begin
      for (int i = 0; i < 4; i++) c[i] = 2 * longint'(rad_q[i]) > lim ? lim : 2 * rad_q[i];
      if (x2 < c[0] && y2 < c[0])
        cov = corner_coverage(c[0], c[0] - x2 - 2, c[0] - y2 - 2);
      else if (x2 >= w2 - c[1] && y2 < c[1])
        cov = corner_coverage(c[1], x2 - (w2 - c[1]), c[1] - y2 - 2);
      else if (x2 < c[2] && y2 >= h2 - c[2])
        cov = corner_coverage(c[2], c[2] - x2 - 2, y2 - (h2 - c[2]));
      else if (x2 >= w2 - c[3] && y2 >= h2 - c[3])
        cov = corner_coverage(c[3], x2 - (w2 - c[3]), y2 - (h2 - c[3]));
    end
    if (cov > 0) begin
      a = fill_q[31:24] * cov;
      ia = 65280 - a;
      o.out_red   = 8'((fill_q[23:16] * a + p.dst_red * ia) / 65280);
      o.out_green = 8'((fill_q[15:8] * a + p.dst_green * ia) / 65280);
      o.out_blue  = 8'((fill_q[7:0] * a + p.dst_blue * ia) / 65280);
      o.covered   = 1'b1;
      o.coverage  = 9'(cov);
    end else begin
      o.out_red   = p.dst_red;
      o.out_green = p.dst_green;
      o.out_blue  = p.dst_blue;
      o.covered   = 1'b0;
      o.coverage  = '0;
    end
    return o;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  assign pending = expected_px.size();

  always @(posedge clk) begin
    rrcb_pkg::result_t e;
    if (rst) begin
      width_q <= rrcb_pkg::RESET_DIM;
      height_q <= rrcb_pkg::RESET_DIM;
      for (int i = 0; i < 4; i++) rad_q[i] <= '0;
      fill_q <= '0;
      expected_px.delete();
      errors = 0;
      covered_cnt = 0;
      partial_cnt = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_px.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = expected_px.pop_front();
          check_field("out_red", e.out_red, res.out_red);
          check_field("out_green", e.out_green, res.out_green);
          check_field("out_blue", e.out_blue, res.out_blue);
          check_field("covered", e.covered, res.covered);
          check_field("coverage", e.coverage, res.coverage);
          if (e.covered) covered_cnt++;
          if (e.covered && e.coverage != 256) partial_cnt++;
        end
      end
      if (pix_valid && pix_ready) expected_px.push_back(blend_pixel(pix));
      if (cfg_we) begin
        case (rrcb_pkg::cfg_reg_t'(cfg_index))
          rrcb_pkg::REG_RECT_WIDTH:  width_q <= cfg_data[11:0];
          rrcb_pkg::REG_RECT_HEIGHT: height_q <= cfg_data[11:0];
          rrcb_pkg::REG_RADIUS_TL:   rad_q[0] <= cfg_data[10:0];
          rrcb_pkg::REG_RADIUS_TR:   rad_q[1] <= cfg_data[10:0];
          rrcb_pkg::REG_RADIUS_BL:   rad_q[2] <= cfg_data[10:0];
          rrcb_pkg::REG_RADIUS_BR:   rad_q[3] <= cfg_data[10:0];
          rrcb_pkg::REG_FILL_COLOR:  fill_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending, covered_cnt, partial_cnt;
  int   pixels_sent = 0;
  int   cur_w = 64, cur_h = 64;
  bit   hold_off = 0;
  logic [10:0] cur_r [4];

  rrcb_cfg_if cfg ();
  rrcb_stream_if #(.T(rrcb_pkg::pixel_t))  pixel_ch ();
  rrcb_stream_if #(.T(rrcb_pkg::result_t)) result_ch ();

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  rounded_rect_coverage_blend_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .pixel(pixel_ch.sink), .result(result_ch.source)
  );

  rrcb_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .pix_valid(pixel_ch.valid), .pix_ready(pixel_ch.ready), .pix(pixel_ch.payload),
    .res_valid(result_ch.valid), .res_ready(result_ch.ready), .res(result_ch.payload),
    .errors(errors), .pending(pending), .covered_cnt(covered_cnt),
    .partial_cnt(partial_cnt)
  );

  initial begin
    cfg.we = 0;
    cfg.index = rrcb_pkg::REG_RECT_WIDTH;
    cfg.data = '0;
    pixel_ch.valid = 0;
    pixel_ch.payload = '0;
    result_ch.ready = 0;
  end

  task automatic write_reg(rrcb_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg.we <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
  endtask

  task automatic set_shape(int w, int h, int r0, int r1, int r2, int r3, logic [31:0] fill);
    write_reg(rrcb_pkg::REG_RECT_WIDTH, w);
    write_reg(rrcb_pkg::REG_RECT_HEIGHT, h);
    write_reg(rrcb_pkg::REG_RADIUS_TL, r0);
    write_reg(rrcb_pkg::REG_RADIUS_TR, r1);
    write_reg(rrcb_pkg::REG_RADIUS_BL, r2);
    write_reg(rrcb_pkg::REG_RADIUS_BR, r3);
    write_reg(rrcb_pkg::REG_FILL_COLOR, fill);
    cfg.we <= 0;
    cur_w = w;
    cur_h = h;
    cur_r[0] = 11'(r0); cur_r[1] = 11'(r1); cur_r[2] = 11'(r2); cur_r[3] = 11'(r3);
  endtask

  task automatic send_pixel(int x, int y, logic [23:0] dst, bit gaps);
    rrcb_pkg::pixel_t p;
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      pixel_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    p.pixel_x = 11'(x);
    p.pixel_y = 11'(y);
    {p.dst_red, p.dst_green, p.dst_blue} = dst;
    pixel_ch.valid <= 1;
    pixel_ch.payload <= p;
    do @(posedge clk); while (!pixel_ch.ready);
    pixels_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    pixel_ch.valid <= 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // pixels mostly near corners and edges, where coverage is interesting
  task automatic random_pixel(bit gaps);
    int x, y, k, span;
    k = $urandom_range(0, 9);
    span = (cur_r[$urandom_range(0, 3)] * 2) + 3;
    x = $urandom_range(0, 2047);
    y = $urandom_range(0, 2047);
    if (k < 7) begin
      x = $urandom_range(0, 1) ? $urandom_range(0, span) : cur_w - 1 - $urandom_range(0, span);
      y = $urandom_range(0, 1) ? $urandom_range(0, span) : cur_h - 1 - $urandom_range(0, span);
      if (x < 0) x = $urandom_range(0, 2047);
      if (y < 0) y = $urandom_range(0, 2047);
      x = x % 2048;
      y = y % 2048;
    end else if (k == 7) begin
      x = $urandom_range(0, 1) ? 0 : 2047;
    end
    send_pixel(x, y, 24'($urandom()), gaps);
  endtask

  initial begin : receiver
    int wait_n;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        result_ch.ready <= 0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      wait_n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
      if (wait_n > 0) begin
        result_ch.ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      result_ch.ready <= 1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin : stimulus
    for (int i = 0; i < 4; i++) cur_r[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset defaults, zero radii, zero fill alpha
    send_pixel(0, 0, 24'hFFFFFF, 0);
    send_pixel(2047, 2047, 24'h000000, 0);
    drain();
    set_shape(64, 64, 10, 20, 5, 40, 32'hFF_FF_00_80);
    send_pixel(0, 0, 24'h123456, 0);
    send_pixel(3, 3, 24'hABCDEF, 0);
    send_pixel(63, 0, 24'h00FF00, 0);
    send_pixel(50, 10, 24'hFFFFFF, 0);
    send_pixel(0, 63, 24'h0000FF, 0);
    send_pixel(63, 63, 24'hFF0000, 0);
    send_pixel(32, 32, 24'h555555, 0);
    send_pixel(2047, 2047, 24'hAAAAAA, 0);
    drain();
    // radii at and well above half the shorter side, dimension extremes
    set_shape(4095, 2048, 1024, 2047, 1024, 2047, 32'h80_10_20_30);
    send_pixel(0, 0, 24'hFFFFFF, 0);
    send_pixel(2047, 0, 24'h000000, 0);
    send_pixel(1000, 1000, 24'h808080, 0);
    send_pixel(2047, 2047, 24'h7F7F7F, 0);
    drain();
    set_shape(0, 1, 1, 0, 0, 0, 32'hFFFFFFFF);
    send_pixel(0, 0, 24'h010203, 0);
    send_pixel(5, 5, 24'hFEFDFC, 0);
    drain();
    set_shape(1, 1, 1, 1, 1, 1, 32'hFF000000);
    send_pixel(0, 0, 24'hFFFFFF, 0);
    send_pixel(1, 1, 24'hFFFFFF, 0);
    drain();
    for (int ph = 0; ph < 14; ph++) begin
      if (ph % 4 == 3)
        set_shape($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom());
      else
        set_shape($urandom_range(4, 120), $urandom_range(4, 120), $urandom_range(0, 40),
                  $urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
                  $urandom());
      if (ph == 5) hold_off = 1;
      for (int n = 0; n < 125; n++) random_pixel(!(ph == 5 || (ph % 3 == 1 && n < 40)));
      drain();
    end
    $display("%0d pixels over 19 shapes, %0d covered, %0d partially", pixels_sent,
             covered_cnt, partial_cnt);
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("FAILURE");
    $finish;
  end
endmodule

### files.f
rtl/rrcb_pkg.sv
rtl/rrcb_stream_if.sv
rtl/rrcb_sqrt_cell.sv
rtl/rrcb_blend.sv
rtl/rounded_rect_coverage_blend_core.sv
dv/rrcb_tb_if.sv
dv/rrcb_checker.sv
dv/tb.sv
